// ----- rtl/stereo_state_variable_filter_defines.svh -----
// Assertion helpers used by the filter RTL top module.
`ifndef STEREO_STATE_VARIABLE_FILTER_DEFINES_SVH
`define STEREO_STATE_VARIABLE_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SSVF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SSVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/ssvf_pkg.sv -----
package ssvf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_W         = 18;
  localparam int INTEG_W        = 32;
  localparam int MODE_W         = 2;
  localparam int CFG_IDX_W      = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A1   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A2   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEFF_A3   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_K  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BYPASS     = 3'd5;

  // reset values
  localparam logic [COEF_W-1:0] COEFF_A1_RESET  = 18'd65536;
  localparam logic [COEF_W-1:0] COEFF_A2_RESET  = 18'd0;
  localparam logic [COEF_W-1:0] COEFF_A3_RESET  = 18'd0;
  localparam logic [COEF_W-1:0] DAMPING_K_RESET = 18'd131072;

  // filter modes; the unused code falls back to bandpass
  localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BP = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_LP;

  // microprogram: 12 steps per channel
  localparam int STEPS  = 12;
  localparam int STEP_W = $clog2(STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
  } ssvf_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_left;
    logic signed [SAMPLE_BITS-1:0] filtered_right;
  } ssvf_out_t;

  typedef struct packed {
    logic [COEF_W-1:0] coeff_a1;
    logic [COEF_W-1:0] coeff_a2;
    logic [COEF_W-1:0] coeff_a3;
    logic [COEF_W-1:0] damping_k;
    logic [MODE_W-1:0] filter_mode;
    logic              bypass;
  } ssvf_cfg_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} ssvf_state_t;

  typedef enum logic [1:0] {C_A1, C_A2, C_A3, C_K} ssvf_coef_t;

  typedef enum logic [1:0] {O_S1, O_V3, O_V1} ssvf_opnd_t;

  typedef enum logic [2:0] {WB_NONE, WB_V3, WB_V1, WB_V2, WB_IC, WB_Y} ssvf_wb_t;

  typedef struct packed {
    ssvf_coef_t coef;
    ssvf_opnd_t opnd;
    logic       mul_hi;
    logic       acc_init;
    logic       acc_add;
    ssvf_wb_t   wb;
  } ssvf_uop_t;

  typedef struct packed {
    logic      start;
    logic      run;
    logic      chan;
    ssvf_uop_t uop;
    logic      fin_load;
  } ssvf_ctrl_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Each multiply issued at step n is accumulated at step n+1.
  function automatic ssvf_uop_t ssvf_uop(input logic [STEP_W-1:0] step);
    ssvf_uop_t u;
    u = '{coef: C_A1, opnd: O_S1, mul_hi: 1'b0, acc_init: 1'b0, acc_add: 1'b0,
          wb: WB_NONE};
    unique case (step)
      4'd0: begin
        u.wb = WB_V3;  u.acc_init = 1'b1;
        u.coef = C_A1; u.opnd = O_S1;
      end
      4'd1: begin
        u.acc_add = 1'b1;
        u.coef = C_A1; u.opnd = O_S1; u.mul_hi = 1'b1;
      end
      4'd2: begin
        u.acc_add = 1'b1;
        u.coef = C_A2; u.opnd = O_V3;
      end
      4'd3: begin
        u.acc_add = 1'b1;
        u.coef = C_A2; u.opnd = O_V3; u.mul_hi = 1'b1;
      end
      4'd4: begin
        u.acc_add = 1'b1;
        u.coef = C_A2; u.opnd = O_S1;
      end
      4'd5: begin
        u.wb = WB_V1;  u.acc_init = 1'b1; u.acc_add = 1'b1;
        u.coef = C_A2; u.opnd = O_S1; u.mul_hi = 1'b1;
      end
      4'd6: begin
        u.acc_add = 1'b1;
        u.coef = C_A3; u.opnd = O_V3;
      end
      4'd7: begin
        u.acc_add = 1'b1;
        u.coef = C_A3; u.opnd = O_V3; u.mul_hi = 1'b1;
      end
      4'd8: begin
        u.acc_add = 1'b1;
        u.coef = C_K;  u.opnd = O_V1;
      end
      4'd9: begin
        u.wb = WB_V2;  u.acc_init = 1'b1; u.acc_add = 1'b1;
        u.coef = C_K;  u.opnd = O_V1; u.mul_hi = 1'b1;
      end
      4'd10: begin
        u.wb = WB_IC;  u.acc_add = 1'b1;
      end
      4'd11: begin
        u.wb = WB_Y;
      end
      default: begin
        u.wb = WB_NONE;
      end
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/stereo_state_variable_filter.sv -----
// Stereo state-variable filter with trapezoidal integrators. Each request
// carries one left/right sample pair (signed Q1.23) and yields one filtered
// pair, saturated to the sample range. Software writes a1, a2, a3 and the
// damping k (unsigned Q2.16) plus the mode (lowpass, highpass, bandpass;
// code 3 acts as bandpass) and bypass; write them only while no request is
// in flight. A filtered request runs the compute microprogram once per
// channel, then passes the load state and the idle state before the next
// acceptance; a bypassed request goes straight to the load state. The
// compute time is set by one shared 19 x 20 bit multiplier, which forms
// each coefficient product in two halves, five products per channel. A
// finished pair waits in the output register; the next request is taken
// as soon as that register has been loaded. Each channel keeps two 32-bit
// integrators that saturate and that bypass leaves untouched.
`include "stereo_state_variable_filter_defines.svh"

module stereo_state_variable_filter #(
  parameter int COEF_FRAC_BITS = ssvf_pkg::COEF_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  // sample request channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ssvf_pkg::ssvf_in_t                  in_data,
  // filtered result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output ssvf_pkg::ssvf_out_t                 out_data,
  // register write port
  input  logic                                cfg_we,
  input  logic [ssvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssvf_pkg::COEF_W-1:0]         cfg_data
);

  ssvf_pkg::ssvf_cfg_t  cfg;
  ssvf_pkg::ssvf_ctrl_t ctrl;
  ssvf_pkg::ssvf_out_t  result;
  logic                 out_free;

  // Output register can take a new pair when empty or being drained.
  assign out_free = !out_valid || out_ready;

  // Register file; out-of-range indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coeff_a1    <= ssvf_pkg::COEFF_A1_RESET;
      cfg.coeff_a2    <= ssvf_pkg::COEFF_A2_RESET;
      cfg.coeff_a3    <= ssvf_pkg::COEFF_A3_RESET;
      cfg.damping_k   <= ssvf_pkg::DAMPING_K_RESET;
      cfg.filter_mode <= ssvf_pkg::MODE_RESET;
      cfg.bypass      <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssvf_pkg::REG_COEFF_A1:    cfg.coeff_a1    <= cfg_data;
        ssvf_pkg::REG_COEFF_A2:    cfg.coeff_a2    <= cfg_data;
        ssvf_pkg::REG_COEFF_A3:    cfg.coeff_a3    <= cfg_data;
        ssvf_pkg::REG_DAMPING_K:   cfg.damping_k   <= cfg_data;
        ssvf_pkg::REG_FILTER_MODE: cfg.filter_mode <= cfg_data[ssvf_pkg::MODE_W-1:0];
        ssvf_pkg::REG_BYPASS:      cfg.bypass      <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Step sequencer: walks the 12-step microprogram once per channel.
  ssvf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .bypass   (cfg.bypass),
    .out_free (out_free),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // Datapath: shared multiplier, accumulator, integrators.
  ssvf_dp #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .cfg     (cfg),
    .in_data (in_data),
    .result  (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.fin_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin_load) begin
      out_data <= result;
    end
  end

  // A taken request keeps the block busy: ready is low in the next cycle.
  `SSVF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
  // Never overwrite a result that has not been taken.
  `SSVF_ASSERT_IMP(a_load_when_free, ctrl.fin_load, !out_valid || out_ready, "result overwritten")
  // A result only shows up from a sequencer load.
  `SSVF_ASSERT_IMP(a_valid_from_load, $rose(out_valid), $past(ctrl.fin_load), "spurious result")

endmodule

// ----- rtl/ssvf_seq.sv -----
module ssvf_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                bypass,
  input  logic                out_free,
  output logic                in_ready,
  output ssvf_pkg::ssvf_ctrl_t ctrl
);

  ssvf_pkg::ssvf_state_t state, state_next;
  logic [ssvf_pkg::STEP_W-1:0] step;
  logic                        chan;
  logic                        last;

  assign last = (step == ssvf_pkg::LAST_STEP);

  always_comb begin
    state_next = state;
    unique case (state)
      ssvf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = bypass ? ssvf_pkg::ST_FIN : ssvf_pkg::ST_RUN;
        end
      end
      ssvf_pkg::ST_RUN: begin
        if (last && chan) begin
          state_next = ssvf_pkg::ST_FIN;
        end
      end
      ssvf_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = ssvf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ssvf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl.run      = 1'b0;
    ctrl.fin_load = 1'b0;
    unique case (state)
      ssvf_pkg::ST_IDLE: in_ready      = 1'b1;
      ssvf_pkg::ST_RUN:  ctrl.run      = 1'b1;
      ssvf_pkg::ST_FIN:  ctrl.fin_load = out_free;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    ctrl.start = in_ready && in_valid;
    ctrl.chan  = chan;
    ctrl.uop   = ssvf_pkg::ssvf_uop(step);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssvf_pkg::ST_IDLE;
      step  <= '0;
      chan  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.run) begin
        if (last) begin
          step <= '0;
          chan <= ~chan;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/ssvf_dp.sv -----
module ssvf_dp #(
  parameter int COEF_FRAC_BITS = ssvf_pkg::COEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ssvf_pkg::ssvf_ctrl_t ctrl,
  input  ssvf_pkg::ssvf_cfg_t  cfg,
  input  ssvf_pkg::ssvf_in_t   in_data,
  output ssvf_pkg::ssvf_out_t  result
);

  localparam int F     = COEF_FRAC_BITS;
  localparam int SB    = ssvf_pkg::SAMPLE_BITS;
  localparam int IW    = ssvf_pkg::INTEG_W;
  localparam int CW    = ssvf_pkg::COEF_W;
  localparam int V3_W  = IW + 1;
  localparam int V1_W  = CW + V3_W + 2 - F;
  localparam int OPW   = ssvf_pkg::imax(V3_W, V1_W);
  localparam int V2_W  = OPW + 1;
  localparam int ACC_W = ssvf_pkg::imax(CW + V3_W + 3, 2 * CW + V3_W + 4 - F);
  localparam int RK_W  = ACC_W - F;
  localparam int Y_W   = ssvf_pkg::imax(RK_W, V2_W) + 2;
  localparam int T1_W  = ssvf_pkg::imax(V1_W, IW) + 2;
  localparam int T2_W  = ssvf_pkg::imax(V2_W, IW) + 2;
  localparam int T_W   = ssvf_pkg::imax(T1_W, T2_W);
  localparam int LO_W  = (OPW + 1) / 2;
  localparam int MB    = LO_W + 1;
  localparam int PW    = CW + 1 + MB;

  localparam logic signed [ACC_W-1:0] HALF = {{(ACC_W-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [T_W-1:0] IC_MAX = {{(T_W-IW+1){1'b0}}, {(IW-1){1'b1}}};
  localparam logic signed [T_W-1:0] IC_MIN = {{(T_W-IW+1){1'b1}}, {(IW-1){1'b0}}};
  localparam logic signed [Y_W-1:0] Y_MAX  = {{(Y_W-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [Y_W-1:0] Y_MIN  = {{(Y_W-SB+1){1'b1}}, {(SB-1){1'b0}}};

  function automatic logic signed [IW-1:0] sat_ic(input logic signed [T_W-1:0] x);
    logic signed [IW-1:0] r;
    if (x > IC_MAX)      r = IC_MAX[IW-1:0];
    else if (x < IC_MIN) r = IC_MIN[IW-1:0];
    else                 r = x[IW-1:0];
    return r;
  endfunction

  function automatic logic signed [SB-1:0] sat_y(input logic signed [Y_W-1:0] x);
    logic signed [SB-1:0] r;
    if (x > Y_MAX)      r = Y_MAX[SB-1:0];
    else if (x < Y_MIN) r = Y_MIN[SB-1:0];
    else                r = x[SB-1:0];
    return r;
  endfunction

  logic signed [SB-1:0]    samp_l, samp_r, y_l, y_r, v0;
  logic signed [IW-1:0]    ic1 [2];
  logic signed [IW-1:0]    ic2 [2];
  logic signed [IW-1:0]    s1, s2;
  logic signed [V3_W-1:0]  v3;
  logic signed [V1_W-1:0]  v1;
  logic signed [V2_W-1:0]  v2;
  logic [CW-1:0]           coef;
  logic signed [OPW-1:0]   opnd;
  logic signed [MB-1:0]    mul_b;
  logic signed [PW-1:0]    mul_p, prod;
  logic                    prod_hi;
  logic signed [ACC_W-1:0] acc, acc_next, addend;
  logic signed [RK_W-1:0]  rk;
  logic signed [T1_W-1:0]  t1;
  logic signed [T2_W-1:0]  t2;
  logic signed [Y_W-1:0]   y_hp, y_sel;

  always_comb begin
    v0 = ctrl.chan ? samp_r : samp_l;
    s1 = ic1[ctrl.chan];
    s2 = ic2[ctrl.chan];

    unique case (ctrl.uop.coef)
      ssvf_pkg::C_A1: coef = cfg.coeff_a1;
      ssvf_pkg::C_A2: coef = cfg.coeff_a2;
      ssvf_pkg::C_A3: coef = cfg.coeff_a3;
      ssvf_pkg::C_K:  coef = cfg.damping_k;
    endcase

    unique case (ctrl.uop.opnd)
      ssvf_pkg::O_S1: opnd = OPW'(s1);
      ssvf_pkg::O_V3: opnd = OPW'(v3);
      ssvf_pkg::O_V1: opnd = OPW'(v1);
      default:        opnd = '0;
    endcase

    // operand split: unsigned low half, signed high half
    if (ctrl.uop.mul_hi) mul_b = MB'(signed'(opnd[OPW-1:LO_W]));
    else                 mul_b = signed'({1'b0, opnd[LO_W-1:0]});
    mul_p = signed'({1'b0, coef}) * mul_b;

    addend   = prod_hi ? (ACC_W'(prod) <<< LO_W) : ACC_W'(prod);
    acc_next = (ctrl.uop.acc_init ? HALF : acc) + (ctrl.uop.acc_add ? addend : '0);

    // floor((x + half) / 2^F)
    rk = signed'(acc[ACC_W-1:F]);

    t1 = (T1_W'(v1) <<< 1) - T1_W'(s1);
    t2 = (T2_W'(v2) <<< 1) - T2_W'(s2);

    y_hp = Y_W'(v0) - Y_W'(rk) - Y_W'(v2);
    unique case (cfg.filter_mode)
      ssvf_pkg::MODE_LP: y_sel = Y_W'(v2);
      ssvf_pkg::MODE_HP: y_sel = y_hp;
      ssvf_pkg::MODE_BP: y_sel = Y_W'(v1);
      default:           y_sel = Y_W'(v1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      samp_l <= in_data.sample_left;
      samp_r <= in_data.sample_right;
      if (cfg.bypass) begin
        y_l <= in_data.sample_left;
        y_r <= in_data.sample_right;
      end
    end
    if (ctrl.run) begin
      prod    <= mul_p;
      prod_hi <= ctrl.uop.mul_hi;
      acc     <= acc_next;
      unique case (ctrl.uop.wb)
        ssvf_pkg::WB_V3: v3 <= V3_W'(v0) - V3_W'(s2);
        ssvf_pkg::WB_V1: v1 <= V1_W'(rk);
        ssvf_pkg::WB_V2: v2 <= V2_W'(s2) + V2_W'(rk);
        ssvf_pkg::WB_Y: begin
          if (ctrl.chan) y_r <= sat_y(y_sel);
          else           y_l <= sat_y(y_sel);
        end
        ssvf_pkg::WB_NONE, ssvf_pkg::WB_IC: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ic1[0] <= '0;
      ic1[1] <= '0;
      ic2[0] <= '0;
      ic2[1] <= '0;
    end else if (ctrl.run && ctrl.uop.wb == ssvf_pkg::WB_IC) begin
      ic1[ctrl.chan] <= sat_ic(T_W'(t1));
      ic2[ctrl.chan] <= sat_ic(T_W'(t2));
    end
  end

  assign result = '{filtered_left: y_l, filtered_right: y_r};

endmodule
